/* hw/rtl/scancode_set1_keyboard_translator_top_macros.svh */
// Assertion macros for the scancode set-1 keyboard translator.
`ifndef SCANCODE_SET1_KEYBOARD_TRANSLATOR_TOP_MACROS_SVH
`define SCANCODE_SET1_KEYBOARD_TRANSLATOR_TOP_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define SC1KT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define SC1KT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sc1kt_pkg.sv */
// Package with types and constants of the scancode set-1 keyboard translator.
package sc1kt_pkg;

    localparam int MAP_DEPTH = 128;
    localparam int PAD_DEPTH = 16;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int PAD_AW    = $clog2(PAD_DEPTH);

    typedef enum logic {
        OP_SCANCODE    = 1'b0,
        OP_TABLE_WRITE = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        TSEL_PLAIN    = 3'd0,
        TSEL_SHIFTED  = 3'd1,
        TSEL_ALTGR    = 3'd2,
        TSEL_NUMPAD   = 3'd3,
        TSEL_ALTDIGIT = 3'd4
    } table_sel_t;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_CHAR = 3'd1,
        KIND_BS   = 3'd2,
        KIND_FUNC = 3'd3,
        KIND_BOOT = 3'd4,
        KIND_LED  = 3'd5
    } kind_t;

    // Modifier bit positions
    localparam int MOD_LSH = 0;
    localparam int MOD_RSH = 1;
    localparam int MOD_LCT = 2;
    localparam int MOD_RCT = 3;
    localparam int MOD_ALT = 4;
    localparam int MOD_AGR = 5;
    localparam int MOD_CAP = 6;
    localparam int MOD_CDN = 7;

    // LED masks
    localparam logic [2:0] LED_SCR   = 3'b001;
    localparam logic [2:0] LED_NUM   = 3'b010;
    localparam logic [2:0] LED_CAP   = 3'b100;
    localparam logic [2:0] LED_RESET = LED_NUM;

    // Prefix states
    localparam logic [1:0] PRE_NONE = 2'd0;
    localparam logic [1:0] PRE_E0   = 2'd1;
    localparam logic [1:0] PRE_E1   = 2'd2;

    // Scancodes
    localparam logic [7:0] SC_NULL      = 8'h00;
    localparam logic [7:0] SC_ESC       = 8'h01;
    localparam logic [7:0] SC_BKSP      = 8'h0E;
    localparam logic [7:0] SC_ENTER     = 8'h1C;
    localparam logic [7:0] SC_CTRL      = 8'h1D;
    localparam logic [7:0] SC_BQUOTE    = 8'h29;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_BSLASH    = 8'h2B;
    localparam logic [7:0] SC_DOT       = 8'h34;
    localparam logic [7:0] SC_SLASH     = 8'h35;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_KP_STAR   = 8'h37;
    localparam logic [7:0] SC_ALT       = 8'h38;
    localparam logic [7:0] SC_SPACE     = 8'h39;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_F1        = 8'h3B;
    localparam logic [7:0] SC_F10       = 8'h44;
    localparam logic [7:0] SC_NUMLOCK   = 8'h45;
    localparam logic [7:0] SC_SCRLOCK   = 8'h46;
    localparam logic [7:0] SC_KP_7      = 8'h47;
    localparam logic [7:0] SC_KP_MINUS  = 8'h4A;
    localparam logic [7:0] SC_KP_PLUS   = 8'h4E;
    localparam logic [7:0] SC_KP_DEL    = 8'h53;
    localparam logic [7:0] SC_ISO       = 8'h56;
    localparam logic [7:0] SC_F11       = 8'h57;
    localparam logic [7:0] SC_F12       = 8'h58;
    localparam logic [7:0] SC_CTRL_BRK  = 8'h9D;
    localparam logic [7:0] SC_LSH_BRK   = 8'hAA;
    localparam logic [7:0] SC_RSH_BRK   = 8'hB6;
    localparam logic [7:0] SC_ALT_BRK   = 8'hB8;
    localparam logic [7:0] SC_CAPS_BRK  = 8'hBA;
    localparam logic [7:0] SC_PREFIX_E0 = 8'hE0;
    localparam logic [7:0] SC_PREFIX_E1 = 8'hE1;

    localparam logic [7:0] CHAR_BS      = 8'h08;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_CASE    = 8'd32;
    localparam logic [7:0] CTRL_MASK    = 8'h1F;
    localparam logic [7:0] ALT_BIT      = 8'h80;
    localparam logic [7:0] F11_OFFSET   = 8'd18;
    localparam logic [PAD_AW-1:0] PAD_IDX_DEL = PAD_AW'(SC_KP_DEL - SC_KP_7);

endpackage

/* hw/rtl/scancode_set1_keyboard_translator_top.sv */
// Top level of the scancode set-1 keyboard translator.
// Usage:
//   s_ channel takes one request per accepted beat: s_tuser is the opcode
//   (0 scancode byte, 1 map table write); s_tdata carries scancode, table
//   select, table index and table value. Map entries must be written before
//   the keys that use them arrive.
//   m_ channel returns exactly one result per request: m_tuser is the result
//   kind, m_tdata carries the result value and the current LED bits.
//   cfg_wr_en/cfg_wr_data write the application keypad bit; write it only
//   while no request is in flight.
// The accepting edge loads stage 1 and reads the five map memories (one read
// port each): the key maps at the scancode, the pad maps at scancode - SC_KP_7.
// When stage 1 fires, modifiers, prefix, LEDs and the Alt-pad code are resolved
// into the result register. One request per cycle unless m_tready stalls it.
// Reset (aresetn low, synchronous) clears modifiers, prefix and the Alt-pad
// code, sets the LEDs to num lock on and clears application keypad mode; map
// contents are left as they are. When m_tready is low the result register
// holds, the stage behind it holds its request, and s_tready drops once both
// are full.
module scancode_set1_keyboard_translator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] opcode
    input  logic [31:0] s_tdata,   // [7:0] scancode, [10:8] table_select,
                                   // [17:11] table_index, [25:18] table_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // [2:0] result_kind
    output logic [15:0] m_tdata    // [7:0] result_value, [10:8] led_bits
);
    import sc1kt_pkg::*;

    `include "scancode_set1_keyboard_translator_top_macros.svh"

    // input fields
    logic [7:0] s_scancode;
    logic [2:0] s_table_select;
    logic [6:0] s_table_index;
    logic [7:0] s_table_value;
    logic       s_accept;
    logic       out_free;
    logic       s1_fire;

    assign s_scancode     = s_tdata[7:0];
    assign s_table_select = s_tdata[10:8];
    assign s_table_index  = s_tdata[17:11];
    assign s_table_value  = s_tdata[25:18];

    // maps
    logic [7:0] plain_mem    [MAP_DEPTH];
    logic [7:0] shifted_mem  [MAP_DEPTH];
    logic [7:0] altgr_mem    [MAP_DEPTH];
    logic [7:0] numpad_mem   [PAD_DEPTH];
    logic [7:0] altdigit_mem [PAD_DEPTH];

    logic [7:0] rd_plain_reg;
    logic [7:0] rd_shifted_reg;
    logic [7:0] rd_altgr_reg;
    logic [7:0] rd_numpad_reg;
    logic [7:0] rd_altdigit_reg;

    logic              map_wr;
    logic              pad_wr;
    logic [MAP_AW-1:0] map_rd_addr;
    logic [PAD_AW-1:0] pad_rd_addr;

    // stage 1 and state
    logic       s1_valid_reg;
    logic       s1_op_reg;
    logic [7:0] s1_sc_reg;
    logic       app_reg;
    logic [7:0] mod_reg, mod_next;
    logic [1:0] pre_reg, pre_next;
    logic [2:0] led_reg, led_next;
    logic [7:0] acc_reg, acc_next;

    // result register
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [7:0] out_value_reg;
    logic [2:0] out_led_reg;
    kind_t      kind_next;
    logic [7:0] value_next;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign map_wr = s_accept && (s_tuser == OP_TABLE_WRITE)
                    && (32'(s_table_index) < MAP_DEPTH);
    assign pad_wr = s_accept && (s_tuser == OP_TABLE_WRITE)
                    && (32'(s_table_index) < PAD_DEPTH);

    assign map_rd_addr = s_scancode[MAP_AW-1:0];
    assign pad_rd_addr = PAD_AW'(s_scancode - SC_KP_7);

    always_ff @(posedge aclk) begin
        if (map_wr && s_table_select == TSEL_PLAIN) begin
            plain_mem[s_table_index[MAP_AW-1:0]] <= s_table_value;
        end
        if (map_wr && s_table_select == TSEL_SHIFTED) begin
            shifted_mem[s_table_index[MAP_AW-1:0]] <= s_table_value;
        end
        if (map_wr && s_table_select == TSEL_ALTGR) begin
            altgr_mem[s_table_index[MAP_AW-1:0]] <= s_table_value;
        end
        if (pad_wr && s_table_select == TSEL_NUMPAD) begin
            numpad_mem[s_table_index[PAD_AW-1:0]] <= s_table_value;
        end
        if (pad_wr && s_table_select == TSEL_ALTDIGIT) begin
            altdigit_mem[s_table_index[PAD_AW-1:0]] <= s_table_value;
        end
        if (s_accept) begin
            rd_plain_reg    <= plain_mem[map_rd_addr];
            rd_shifted_reg  <= shifted_mem[map_rd_addr];
            rd_altgr_reg    <= altgr_mem[map_rd_addr];
            rd_numpad_reg   <= numpad_mem[pad_rd_addr];
            rd_altdigit_reg <= altdigit_mem[pad_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
        if (s_accept) begin
            s1_op_reg <= s_tuser;
            s1_sc_reg <= s_scancode;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            app_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            app_reg <= cfg_wr_data;
        end
    end

    // modifier views
    logic shift_held, ctrl_held, alt_held, agr_held, caps_on;
    logic [7:0] sel_ch, up_ch, self_ch;
    logic       self_emit;
    logic [PAD_AW-1:0] pad_idx;
    logic       e0_seen;

    assign shift_held = mod_reg[MOD_LSH] || mod_reg[MOD_RSH];
    assign ctrl_held  = mod_reg[MOD_LCT] || mod_reg[MOD_RCT];
    assign alt_held   = mod_reg[MOD_ALT];
    assign agr_held   = mod_reg[MOD_AGR];
    assign caps_on    = mod_reg[MOD_CAP];
    assign e0_seen    = (pre_reg == PRE_E0);
    assign pad_idx    = PAD_AW'(s1_sc_reg - SC_KP_7);

    // plain/shifted/AltGr key lookup with case, control and Alt folding
    always_comb begin
        if (agr_held) begin
            sel_ch = rd_altgr_reg;
        end else if (shift_held || ctrl_held) begin
            sel_ch = rd_shifted_reg;
        end else begin
            sel_ch = rd_plain_reg;
        end
        up_ch = sel_ch;
        if ((ctrl_held || caps_on)
            && (sel_ch inside {[8'h61:8'h7A], [8'd224:8'd254]})) begin
            up_ch = sel_ch - CHAR_CASE;
        end
        self_ch = up_ch;
        if (ctrl_held) begin
            self_ch = self_ch & CTRL_MASK;
        end
        if (alt_held) begin
            self_ch = self_ch | ALT_BIT;
        end
        self_emit = !s1_sc_reg[7] && (sel_ch != 8'd0);
    end

    always_comb begin
        mod_next   = mod_reg;
        pre_next   = pre_reg;
        led_next   = led_reg;
        acc_next   = acc_reg;
        kind_next  = KIND_NONE;
        value_next = 8'd0;
        if (s1_op_reg == OP_SCANCODE) begin
            pre_next = PRE_NONE;
            case (s1_sc_reg) inside
                SC_PREFIX_E0: pre_next = PRE_E0;
                SC_PREFIX_E1: pre_next = PRE_E1;
                SC_NULL: ;
                SC_BKSP: begin
                    if (!e0_seen) begin
                        kind_next  = KIND_BS;
                        value_next = CHAR_BS;
                    end
                end
                SC_ENTER: begin
                    if (!(e0_seen && app_reg) && self_emit) begin
                        kind_next  = KIND_CHAR;
                        value_next = self_ch;
                    end
                end
                SC_CTRL: begin
                    if (pre_reg != PRE_NONE) begin
                        mod_next[MOD_RCT] = 1'b1;
                    end else begin
                        mod_next[MOD_LCT] = 1'b1;
                    end
                end
                SC_LSHIFT: mod_next[MOD_LSH] = 1'b1;
                SC_RSHIFT: mod_next[MOD_RSH] = 1'b1;
                SC_SLASH: begin
                    if (!e0_seen) begin
                        if (self_emit) begin
                            kind_next  = KIND_CHAR;
                            value_next = self_ch;
                        end
                    end else if (!app_reg) begin
                        kind_next  = KIND_CHAR;
                        value_next = CHAR_SLASH;
                    end
                end
                SC_KP_STAR, SC_KP_MINUS, SC_KP_PLUS: begin
                    if (!app_reg && self_emit) begin
                        kind_next  = KIND_CHAR;
                        value_next = self_ch;
                    end
                end
                SC_ALT: begin
                    if (pre_reg != PRE_NONE) begin
                        mod_next[MOD_AGR] = 1'b1;
                    end else begin
                        mod_next[MOD_ALT] = 1'b1;
                    end
                end
                SC_CAPS: begin
                    // toggle only on the first make of a held key
                    if (!mod_reg[MOD_CDN]) begin
                        mod_next[MOD_CAP] = !mod_reg[MOD_CAP];
                        mod_next[MOD_CDN] = 1'b1;
                        led_next   = led_reg ^ LED_CAP;
                        kind_next  = KIND_LED;
                        value_next = {5'd0, led_next};
                    end
                end
                [SC_F1:SC_F10], SC_F11, SC_F12: begin
                    if (!alt_held) begin
                        kind_next  = KIND_FUNC;
                        value_next = (s1_sc_reg <= SC_F10) ? s1_sc_reg - SC_F1
                                                          : s1_sc_reg - SC_F1 - F11_OFFSET;
                    end
                end
                SC_NUMLOCK: begin
                    if (!app_reg) begin
                        led_next   = led_reg ^ LED_NUM;
                        kind_next  = KIND_LED;
                        value_next = {5'd0, led_next};
                    end
                end
                SC_SCRLOCK: begin
                    led_next   = led_reg ^ LED_SCR;
                    kind_next  = KIND_LED;
                    value_next = {5'd0, led_next};
                end
                [SC_KP_7:SC_KP_DEL]: begin
                    if (pad_idx == PAD_IDX_DEL && ctrl_held && (alt_held || agr_held)) begin
                        kind_next = KIND_BOOT;
                    end else if (!e0_seen) begin
                        if (alt_held && pad_idx != PAD_IDX_DEL) begin
                            acc_next = 8'(acc_reg * 8'd10 + rd_altdigit_reg);
                        end else if ((led_reg & LED_NUM) != 3'd0) begin
                            kind_next  = KIND_CHAR;
                            value_next = rd_numpad_reg;
                        end
                    end
                end
                [SC_ESC:SC_BQUOTE], [SC_BSLASH:SC_DOT], SC_SPACE, SC_ISO: begin
                    if (self_emit) begin
                        kind_next  = KIND_CHAR;
                        value_next = self_ch;
                    end
                end
                SC_CTRL_BRK: begin
                    if (pre_reg != PRE_NONE) begin
                        mod_next[MOD_RCT] = 1'b0;
                    end else begin
                        mod_next[MOD_LCT] = 1'b0;
                    end
                end
                SC_LSH_BRK: mod_next[MOD_LSH] = 1'b0;
                SC_RSH_BRK: mod_next[MOD_RSH] = 1'b0;
                SC_ALT_BRK: begin
                    if (pre_reg != PRE_NONE) begin
                        mod_next[MOD_AGR] = 1'b0;
                    end else begin
                        mod_next[MOD_ALT] = 1'b0;
                        // release the Alt-pad code
                        if (acc_reg != 8'd0) begin
                            kind_next  = KIND_CHAR;
                            value_next = acc_reg;
                            acc_next   = 8'd0;
                        end
                    end
                end
                SC_CAPS_BRK: mod_next[MOD_CDN] = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= 8'd0;
            pre_reg <= PRE_NONE;
            led_reg <= LED_RESET;
            acc_reg <= 8'd0;
        end else if (s1_fire) begin
            mod_reg <= mod_next;
            pre_reg <= pre_next;
            led_reg <= led_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s1_valid_reg;
        end
        if (s1_fire) begin
            out_kind_reg  <= kind_next;
            out_value_reg <= value_next;
            out_led_reg   <= led_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'd0, out_led_reg, out_value_reg};

    `SC1KT_ASSERT_NEXT(a_accept_loads_stage, aclk, aresetn,
        s_tvalid && s_tready, s1_valid_reg, "accepted request did not enter stage 1")
    `SC1KT_ASSERT_SAME(a_led_result_matches, aclk, aresetn,
        m_tvalid && m_tuser == KIND_LED, m_tdata[7:0] == {5'd0, m_tdata[10:8]},
        "LED result value differs from LED bits")
    `SC1KT_ASSERT_SAME(a_func_index_range, aclk, aresetn,
        m_tvalid && m_tuser == KIND_FUNC, m_tdata[7:0] < 8'd12,
        "function key index out of range")
    `SC1KT_ASSERT_SAME(a_prefix_legal, aclk, aresetn,
        1'b1, pre_reg != 2'd3, "prefix state corrupted")

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the set-1 scancode to character translator.
module tb_top;
    import sc1kt_pkg::*;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         PHASE_ITEMS  = 215;
    localparam logic [7:0] SC_KEY_Q     = 8'h10;
    localparam logic [7:0] SC_KEY_A     = 8'h1E;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [2:0] leds;
    } key_result_t;

    class keymap_scoreboard;
        localparam logic [7:0] LOWER_A  = 8'h61;
        localparam logic [7:0] LOWER_Z  = 8'h7A;
        localparam logic [7:0] LATIN_LO = 8'd224;
        localparam logic [7:0] LATIN_HI = 8'd254;

        bit          keypad_app;
        logic [7:0]  mods;
        logic [1:0]  prefix;
        logic [2:0]  leds;
        logic [7:0]  alt_code;
        logic [7:0]  plain_tbl [MAP_DEPTH];
        logic [7:0]  shift_tbl [MAP_DEPTH];
        logic [7:0]  altgr_tbl [MAP_DEPTH];
        logic [7:0]  pad_tbl [PAD_DEPTH];
        logic [7:0]  altpad_tbl [PAD_DEPTH];
        kind_t       out_kind;
        logic [7:0]  out_value;
        key_result_t due_q [$];
        int          errors;
        int          kind_count [8];

        function new();
            keypad_app = 1'b0;
            mods       = '0;
            prefix     = PRE_NONE;
            leds       = LED_RESET;
            alt_code   = '0;
            errors     = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        function void emit(kind_t k, logic [7:0] v);
            out_kind  = k;
            out_value = v;
        endfunction

        function void flip_led(logic [2:0] mask);
            leds = leds ^ mask;
            emit(KIND_LED, {5'b0, leds});
        endfunction

        function void type_char(logic [7:0] sc);
            logic [7:0] ch;
            logic       ctrl;
            ctrl = mods[MOD_LCT] | mods[MOD_RCT];
            if (mods[MOD_AGR])
                ch = altgr_tbl[sc[6:0]];
            else if (ctrl || mods[MOD_LSH] || mods[MOD_RSH])
                ch = shift_tbl[sc[6:0]];
            else
                ch = plain_tbl[sc[6:0]];
            if (ch != 8'h00) begin
                if ((ctrl || mods[MOD_CAP]) &&
                    ((ch >= LOWER_A && ch <= LOWER_Z) || (ch >= LATIN_LO && ch <= LATIN_HI)))
                    ch = ch - CHAR_CASE;
                if (ctrl)
                    ch = ch & CTRL_MASK;
                if (mods[MOD_ALT])
                    ch = ch | ALT_BIT;
                emit(KIND_CHAR, ch);
            end
        endfunction

        function void note_request(logic op, logic [31:0] d);
            logic [7:0] sc;
            logic [2:0] sel;
            logic [6:0] idx;
            logic [7:0] val;
            logic [3:0] pad_idx;
            logic       ctrl;
            sc   = d[7:0];
            sel  = d[10:8];
            idx  = d[17:11];
            val  = d[25:18];
            ctrl = mods[MOD_LCT] | mods[MOD_RCT];
            emit(KIND_NONE, 8'h00);
            if (op == OP_TABLE_WRITE) begin
                case (sel)
                    TSEL_PLAIN:    plain_tbl[idx] = val;
                    TSEL_SHIFTED:  shift_tbl[idx] = val;
                    TSEL_ALTGR:    altgr_tbl[idx] = val;
                    TSEL_NUMPAD:   if (idx < PAD_DEPTH) pad_tbl[idx[3:0]] = val;
                    TSEL_ALTDIGIT: if (idx < PAD_DEPTH) altpad_tbl[idx[3:0]] = val;
                    default: ;
                endcase
            end else if (sc == SC_PREFIX_E0) begin
                prefix = PRE_E0;
            end else if (sc == SC_PREFIX_E1) begin
                prefix = PRE_E1;
            end else begin
                if (sc == SC_BKSP) begin
                    if (prefix != PRE_E0) emit(KIND_BS, CHAR_BS);
                end else if (sc == SC_ENTER) begin
                    if (!(prefix == PRE_E0 && keypad_app)) type_char(sc);
                end else if (sc == SC_CTRL) begin
                    mods[(prefix != PRE_NONE) ? MOD_RCT : MOD_LCT] = 1'b1;
                end else if (sc == SC_LSHIFT) begin
                    mods[MOD_LSH] = 1'b1;
                end else if (sc == SC_RSHIFT) begin
                    mods[MOD_RSH] = 1'b1;
                end else if (sc == SC_SLASH) begin
                    if (prefix != PRE_E0) type_char(sc);
                    else if (!keypad_app) emit(KIND_CHAR, CHAR_SLASH);
                end else if (sc == SC_KP_STAR || sc == SC_KP_MINUS || sc == SC_KP_PLUS) begin
                    if (!keypad_app) type_char(sc);
                end else if (sc == SC_ALT) begin
                    mods[(prefix != PRE_NONE) ? MOD_AGR : MOD_ALT] = 1'b1;
                end else if (sc == SC_CAPS) begin
                    if (!mods[MOD_CDN]) begin
                        mods[MOD_CAP] = ~mods[MOD_CAP];
                        mods[MOD_CDN] = 1'b1;
                        flip_led(LED_CAP);
                    end
                end else if ((sc >= SC_F1 && sc <= SC_F10) || sc == SC_F11 || sc == SC_F12) begin
                    if (!mods[MOD_ALT])
                        emit(KIND_FUNC, (sc <= SC_F10) ? sc - SC_F1 : sc - SC_F1 - F11_OFFSET);
                end else if (sc == SC_NUMLOCK) begin
                    if (!keypad_app) flip_led(LED_NUM);
                end else if (sc == SC_SCRLOCK) begin
                    flip_led(LED_SCR);
                end else if (sc >= SC_KP_7 && sc <= SC_KP_DEL) begin
                    pad_idx = 4'(sc - SC_KP_7);
                    // Reboot check ignores the prefix; the rest of the pad does not
                    if (pad_idx == PAD_IDX_DEL && ctrl && (mods[MOD_ALT] || mods[MOD_AGR]))
                        emit(KIND_BOOT, 8'h00);
                    else if (prefix != PRE_E0) begin
                        if (mods[MOD_ALT] && pad_idx != PAD_IDX_DEL)
                            alt_code = 8'(alt_code * 8'd10 + altpad_tbl[pad_idx]);
                        else if ((leds & LED_NUM) != 3'b000)
                            emit(KIND_CHAR, pad_tbl[pad_idx]);
                    end
                end else if ((sc >= SC_ESC && sc <= SC_BQUOTE) ||
                             (sc >= SC_BSLASH && sc <= SC_DOT) ||
                             sc == SC_SPACE || sc == SC_ISO) begin
                    type_char(sc);
                end else if (sc == SC_CTRL_BRK) begin
                    mods[(prefix != PRE_NONE) ? MOD_RCT : MOD_LCT] = 1'b0;
                end else if (sc == SC_LSH_BRK) begin
                    mods[MOD_LSH] = 1'b0;
                end else if (sc == SC_RSH_BRK) begin
                    mods[MOD_RSH] = 1'b0;
                end else if (sc == SC_ALT_BRK) begin
                    if (prefix != PRE_NONE) begin
                        mods[MOD_AGR] = 1'b0;
                    end else begin
                        mods[MOD_ALT] = 1'b0;
                        if (alt_code != 8'h00) begin
                            emit(KIND_CHAR, alt_code);
                            alt_code = 8'h00;
                        end
                    end
                end else if (sc == SC_CAPS_BRK) begin
                    mods[MOD_CDN] = 1'b0;
                end
                prefix = PRE_NONE;
            end
            due_q.push_back('{kind: out_kind, value: out_value, leds: leds});
        endfunction

        function void check_result(logic [2:0] kind, logic [15:0] d);
            key_result_t want;
            if (due_q.size() == 0) begin
                $error("result with no request pending: kind %0d data %h", kind, d);
                errors++;
            end else begin
                want = due_q.pop_front();
                kind_count[want.kind]++;
                if (kind !== want.kind) begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, kind);
                    errors++;
                end
                if (d[7:0] !== want.value) begin
                    $error("result_value: expected %h, actual %h", want.value, d[7:0]);
                    errors++;
                end
                if (d[10:8] !== want.leds) begin
                    $error("led_bits: expected %b, actual %b", want.leds, d[10:8]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic        s_tuser     = 1'b0;
    logic [31:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [2:0]  m_tuser;
    logic [15:0] m_tdata;

    keymap_scoreboard sb;
    bit idle_on     = 1'b1;
    int n_sent      = 0;
    int n_writes    = 0;
    int cycle_count = 0;

    scancode_set1_keyboard_translator_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 20);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.due_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Hold valid across back-to-back requests; drop it only for a gap
    task automatic send_request(logic op, logic [31:0] d);
        while (idle_on && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, d);
        n_sent++;
    endtask

    task automatic press(logic [7:0] sc);
        logic [31:0] d;
        d      = $urandom;
        d[7:0] = sc;
        send_request(OP_SCANCODE, d);
    endtask

    task automatic load_entry(logic [2:0] sel, int idx, logic [7:0] val);
        logic [31:0] d;
        d        = $urandom;
        d[10:8]  = sel;
        d[17:11] = 7'(idx);
        d[25:18] = val;
        send_request(OP_TABLE_WRITE, d);
        n_writes++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_keypad_mode(bit mode);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.keypad_app = mode;
    endtask

    // Lean toward letters and the accented range so case folding gets hit
    function automatic logic [7:0] pick_char();
        case ($urandom_range(5))
            0: return 8'($urandom_range(8'h61, 8'h7A));
            1: return 8'($urandom_range(224, 254));
            2: return 8'h00;
            3: begin
                case ($urandom_range(3))
                    0: return 8'h60;
                    1: return 8'h7B;
                    2: return 8'd223;
                    default: return 8'd255;
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            press(8'($urandom_range(SC_ESC, SC_F12)));
        end else if (pick < 42) begin
            if ($urandom_range(3) == 0) press(SC_PREFIX_E0);
            case ($urandom_range(9))
                0: press(SC_CTRL);
                1: press(SC_LSHIFT);
                2: press(SC_RSHIFT);
                3: press(SC_ALT);
                4: press(SC_CAPS);
                5: press(SC_CTRL_BRK);
                6: press(SC_LSH_BRK);
                7: press(SC_RSH_BRK);
                8: press(SC_ALT_BRK);
                default: press(SC_CAPS_BRK);
            endcase
        end else if (pick < 50) begin
            press(SC_PREFIX_E0);
            press(8'($urandom_range(255)));
        end else if (pick < 56) begin
            press(SC_PREFIX_E1);
            press(8'($urandom_range(255)));
        end else if (pick < 64) begin
            // Alt held while typing a decimal code on the keypad
            press(SC_ALT);
            repeat ($urandom_range(1, 4)) press(8'($urandom_range(SC_KP_7, SC_KP_DEL)));
            press(SC_ALT_BRK);
        end else if (pick < 68) begin
            if ($urandom_range(1)) press(SC_PREFIX_E0);
            press(SC_CTRL);
            if ($urandom_range(1)) press(SC_PREFIX_E0);
            press(SC_ALT);
            if ($urandom_range(1)) press(SC_PREFIX_E0);
            press(SC_KP_DEL);
            if ($urandom_range(1)) press(SC_PREFIX_E0);
            press(SC_ALT_BRK);
            press(SC_CTRL_BRK);
        end else if (pick < 76) begin
            case ($urandom_range(4))
                0: load_entry(TSEL_PLAIN, $urandom_range(MAP_DEPTH - 1), pick_char());
                1: load_entry(TSEL_SHIFTED, $urandom_range(MAP_DEPTH - 1), pick_char());
                2: load_entry(TSEL_ALTGR, $urandom_range(MAP_DEPTH - 1), pick_char());
                3: load_entry(TSEL_NUMPAD, $urandom_range(PAD_DEPTH - 1), pick_char());
                default: load_entry(TSEL_ALTDIGIT, $urandom_range(PAD_DEPTH - 1), pick_char());
            endcase
        end else if (pick < 80) begin
            load_entry(3'($urandom_range(7)), $urandom_range(127), 8'($urandom_range(255)));
        end else begin
            press(8'($urandom_range(255)));
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        set_keypad_mode(1'b0);

        // Fill every map entry before any key can look one up
        for (int i = 0; i < MAP_DEPTH; i++) begin
            load_entry(TSEL_PLAIN, i, pick_char());
            load_entry(TSEL_SHIFTED, i, pick_char());
            load_entry(TSEL_ALTGR, i, pick_char());
        end
        for (int i = 0; i < PAD_DEPTH; i++) begin
            load_entry(TSEL_NUMPAD, i, pick_char());
            load_entry(TSEL_ALTDIGIT, i, pick_char());
        end

        load_entry(TSEL_PLAIN, SC_KEY_A, 8'h61);
        load_entry(TSEL_SHIFTED, SC_KEY_A, 8'h00);
        load_entry(TSEL_ALTGR, SC_KEY_Q, 8'd224);
        load_entry(TSEL_NUMPAD, 0, 8'h00);
        load_entry(3'd7, 127, 8'hFF);
        load_entry(TSEL_ALTDIGIT, 100, 8'hFF);
        press(SC_KEY_A);
        press(SC_LSHIFT);
        press(SC_KEY_A);
        press(SC_CAPS);
        press(SC_KEY_A);
        press(SC_CTRL);
        press(SC_ALT);
        press(SC_KP_DEL);
        press(SC_CTRL_BRK);
        press(SC_KP_7);
        press(SC_KP_7);
        press(SC_ALT_BRK);
        press(SC_KP_7);
        press(SC_PREFIX_E0);
        press(SC_SLASH);
        press(SC_PREFIX_E0);
        press(SC_ALT);
        press(SC_KEY_Q);
        press(SC_F1);
        press(SC_F12);
        press(SC_NUMLOCK);
        press(SC_BKSP);

        for (int phase = 0; phase < 4; phase++) begin
            set_keypad_mode(phase % 2 == 0);
            idle_on = (phase != 1);
            for (int target = n_sent + PHASE_ITEMS; n_sent < target; )
                random_sequence();
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("Ran %0d requests (%0d map writes) across four keypad-mode phases",
                 n_sent, n_writes);
        $display("Results: %0d char, %0d backspace, %0d fkey, %0d reboot, %0d led, %0d none",
                 sb.kind_count[KIND_CHAR], sb.kind_count[KIND_BS], sb.kind_count[KIND_FUNC],
                 sb.kind_count[KIND_BOOT], sb.kind_count[KIND_LED], sb.kind_count[KIND_NONE]);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
